/* sv/pcoa_pkg.sv */
// Shared types and constants of the per-channel oversample averager.
package pcoa_pkg;

  localparam int unsigned NUM_CHANNELS_DEF  = 4;
  localparam int unsigned BLOCK_SAMPLES_DEF = 16;

  localparam int unsigned CHAN_W    = 2;
  localparam int unsigned RAW_W     = 10;
  localparam int unsigned SHIFT_IN  = 2;
  localparam int unsigned SUM_W     = 16;
  localparam int unsigned AVG_W     = 12;
  localparam int unsigned SCALE_W   = 17;
  localparam int unsigned VOLT_W    = 17;
  localparam int unsigned VOLT_SH   = 12;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(50000);

  typedef struct packed {
    logic [CHAN_W-1:0] channel_index;
    logic [RAW_W-1:0]  raw_reading;
  } in_req_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_channel;
    logic [AVG_W-1:0]  average_value;
    logic [VOLT_W-1:0] voltage;
  } out_rsp_t;

endpackage

/* sv/per_channel_oversample_average.sv */
// Per-channel oversampling averager: accumulate, divide by block size, scale to voltage.
//
// Input requests carry a channel index and a 10-bit converter reading on a
// valid/ready channel. Each reading, shifted left by two, is added to its
// channel's running sum. The reading that completes a block of BLOCK_SAMPLES
// for that channel yields one result (channel, 12-bit average, voltage) and
// clears that channel's sum and count; other readings yield nothing. A
// reading whose channel index is NUM_CHANNELS or above is taken and dropped.
// The voltage is average * ref_scale >> 12. ref_scale is written through cfg_we_i /
// cfg_wdata_i; the user must write it only while the block is idle, which the block does
// not enforce. Throughput: one reading per cycle while in_ready_o is high. A result
// passes through one register per stage after its completing reading is taken
// (accumulate, reciprocal-multiply divide, scale multiply).
// Reset clears all sums and counts, empties the pipeline and sets ref_scale
// to 50000. When the receiver stalls, the result holds on the output and the
// pipeline fills; in_ready_o drops only once every stage holds a result.
module per_channel_oversample_average #(
  parameter int unsigned NUM_CHANNELS  = pcoa_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned BLOCK_SAMPLES = pcoa_pkg::BLOCK_SAMPLES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pcoa_pkg::SCALE_W-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  pcoa_pkg::in_req_t              in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output pcoa_pkg::out_rsp_t             out_rsp_o
);

  localparam int unsigned CNT_W     = $clog2(BLOCK_SAMPLES);
  localparam int unsigned SUM_W     = pcoa_pkg::SUM_W;
  localparam int unsigned DIV_SHIFT = SUM_W + CNT_W;
  localparam int unsigned RECIP     = ((1 << DIV_SHIFT) + BLOCK_SAMPLES - 1) / BLOCK_SAMPLES;
  localparam int unsigned RECIP_W   = SUM_W + 2;
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;
  localparam int unsigned VPROD_W   = pcoa_pkg::AVG_W + pcoa_pkg::SCALE_W;
  localparam int unsigned IDX_W     = 5;
  localparam logic [CNT_W-1:0]   LAST_CNT  = CNT_W'(BLOCK_SAMPLES - 1);
  localparam logic [RECIP_W-1:0] RECIP_VAL = RECIP_W'(RECIP);

  logic [pcoa_pkg::SCALE_W-1:0] scale_q;
  logic [SUM_W-1:0]             sum_q [NUM_CHANNELS];
  logic [CNT_W-1:0]             cnt_q [NUM_CHANNELS];

  logic                          v1_q, v2_q, v3_q;
  logic [SUM_W-1:0]              sum1_q;
  logic [pcoa_pkg::CHAN_W-1:0]   ch1_q, ch2_q;
  logic [pcoa_pkg::AVG_W-1:0]    avg2_q;
  pcoa_pkg::out_rsp_t            rsp3_q;

  logic                          en3, en2, en1, accept;
  logic                          ch_ok, last_hit;
  logic [SUM_W-1:0]              sum_sel, sum_new;
  logic [CNT_W-1:0]              cnt_sel;
  logic [PROD_W-1:0]             prod1;
  logic [VPROD_W-1:0]            vprod2;

  assign en3    = !v3_q || out_ready_i;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;
  assign accept = in_valid_i && in_ready_o;

  assign in_ready_o  = en1;
  assign out_valid_o = v3_q;
  assign out_rsp_o   = rsp3_q;

  always_comb begin
    ch_ok   = 1'b0;
    sum_sel = '0;
    cnt_sel = '0;
    for (int unsigned c = 0; c < NUM_CHANNELS; c++) begin
      if (IDX_W'(in_req_i.channel_index) == IDX_W'(c)) begin
        ch_ok   = 1'b1;
        sum_sel = sum_q[c];
        cnt_sel = cnt_q[c];
      end
    end
    sum_new  = sum_sel + SUM_W'({in_req_i.raw_reading, pcoa_pkg::SHIFT_IN'(0)});
    last_hit = ch_ok && (cnt_sel == LAST_CNT);
  end

  assign prod1  = PROD_W'(sum1_q) * PROD_W'(RECIP_VAL);
  assign vprod2 = VPROD_W'(avg2_q) * VPROD_W'(scale_q);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= pcoa_pkg::SCALE_RESET;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  // Accumulate per channel; clear on block end.
  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sum_q[g] <= '0;
        cnt_q[g] <= '0;
      end else if (accept && IDX_W'(in_req_i.channel_index) == IDX_W'(g)) begin
        if (cnt_q[g] == LAST_CNT) begin
          sum_q[g] <= '0;
          cnt_q[g] <= '0;
        end else begin
          sum_q[g] <= sum_new;
          cnt_q[g] <= cnt_q[g] + CNT_W'(1);
        end
      end
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= accept && last_hit;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (en1) begin
      sum1_q <= sum_new;
      ch1_q  <= in_req_i.channel_index;
    end
    if (en2) begin
      avg2_q <= prod1[DIV_SHIFT +: pcoa_pkg::AVG_W];
      ch2_q  <= ch1_q;
    end
    if (en3) begin
      rsp3_q.out_channel   <= ch2_q;
      rsp3_q.average_value <= avg2_q;
      rsp3_q.voltage       <= vprod2[pcoa_pkg::VOLT_SH +: pcoa_pkg::VOLT_W];
    end
  end

endmodule

/* sim/tb_per_channel_oversample_average.sv */
// Self-checking testbench for the per-channel oversample averager.
`timescale 1ns / 100ps

module tb_per_channel_oversample_average;

  localparam int unsigned NUM_CH       = pcoa_pkg::NUM_CHANNELS_DEF;
  localparam int unsigned BLOCK        = pcoa_pkg::BLOCK_SAMPLES_DEF;
  localparam int unsigned PIPE_LATENCY = 3;
  localparam int unsigned CYCLE_LIMIT  = 300000;

  typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_BURSTY} ready_mode_e;
  typedef enum int {FILL_ZERO, FILL_FULL, FILL_RANDOM} fill_mode_e;

  logic                         clk_i;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic [pcoa_pkg::SCALE_W-1:0] cfg_wdata_i = '0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  pcoa_pkg::in_req_t            in_req_i    = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  pcoa_pkg::out_rsp_t           out_rsp_o;

  // Reference state of the averager
  logic [pcoa_pkg::SUM_W-1:0]   chan_sum [NUM_CH];
  int unsigned                  chan_count [NUM_CH];
  logic [pcoa_pkg::SCALE_W-1:0] scale_reg;
  pcoa_pkg::out_rsp_t           avg_expected_q[$];

  ready_mode_e        rdy_mode   = RDY_ALWAYS;
  bit                 gaps_on    = 1'b0;
  int                 burst_left = 0;
  int                 rdy_left   = 0;
  bit                 rdy_hold   = 1'b0;
  int                 fail_count = 0;
  int unsigned        cycle_count = 0;

  per_channel_oversample_average u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_per_channel_oversample_average: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Accumulate one accepted reading; queue an average when a block completes.
  task automatic accumulate_reading(input pcoa_pkg::in_req_t r);
    int unsigned                                  ch;
    logic [pcoa_pkg::SUM_W-1:0]                   next_sum;
    logic [pcoa_pkg::AVG_W-1:0]                   avg;
    logic [pcoa_pkg::AVG_W+pcoa_pkg::SCALE_W-1:0] prod;
    pcoa_pkg::out_rsp_t                           res;
    ch = r.channel_index;
    if (ch >= NUM_CH) return;
    next_sum = chan_sum[ch] + (pcoa_pkg::SUM_W'(r.raw_reading) << pcoa_pkg::SHIFT_IN);
    if (chan_count[ch] + 1 < BLOCK) begin
      chan_sum[ch]   = next_sum;
      chan_count[ch] = chan_count[ch] + 1;
    end else begin
      avg  = pcoa_pkg::AVG_W'(next_sum / BLOCK);
      prod = avg * scale_reg;
      res.out_channel   = pcoa_pkg::CHAN_W'(ch);
      res.average_value = avg;
      res.voltage       = pcoa_pkg::VOLT_W'(prod >> pcoa_pkg::VOLT_SH);
      avg_expected_q.push_back(res);
      chan_sum[ch]   = '0;
      chan_count[ch] = 0;
    end
  endtask

  task automatic compare_average(input pcoa_pkg::out_rsp_t got);
    pcoa_pkg::out_rsp_t exp_rsp;
    if (avg_expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result ch=%0d avg=%0d volt=%0d",
                                got.out_channel, got.average_value, got.voltage));
      return;
    end
    exp_rsp = avg_expected_q.pop_front();
    if (got.out_channel !== exp_rsp.out_channel)
      report_mismatch($sformatf("out_channel got %0d exp %0d",
                                got.out_channel, exp_rsp.out_channel));
    if (got.average_value !== exp_rsp.average_value)
      report_mismatch($sformatf("average_value ch %0d got %0d exp %0d", exp_rsp.out_channel,
                                got.average_value, exp_rsp.average_value));
    if (got.voltage !== exp_rsp.voltage)
      report_mismatch($sformatf("voltage ch %0d got %0d exp %0d", exp_rsp.out_channel,
                                got.voltage, exp_rsp.voltage));
  endtask

  initial begin
    foreach (chan_sum[c]) begin
      chan_sum[c]   = '0;
      chan_count[c] = 0;
    end
    scale_reg = pcoa_pkg::SCALE_RESET;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) accumulate_reading(in_req_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) compare_average(out_rsp_o);
  end

  // Receiver stall pattern
  always @(posedge clk_i) begin
    case (rdy_mode)
      RDY_ALWAYS: begin
        out_ready_i <= 1'b1;
      end
      RDY_RANDOM: begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        if (rdy_left == 0) begin
          rdy_hold = !rdy_hold;
          rdy_left = rdy_hold ? $urandom_range(1, 24) : $urandom_range(1, 4);
        end
        rdy_left--;
        out_ready_i <= !rdy_hold;
      end
    endcase
  end

  // Send one request and hold it until accepted.
  task automatic send_reading(input pcoa_pkg::in_req_t r);
    if (gaps_on && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left > 0) burst_left--;
  endtask

  function automatic logic [pcoa_pkg::RAW_W-1:0] fill_reading(input fill_mode_e mode);
    case (mode)
      FILL_ZERO: return '0;
      FILL_FULL: return '1;
      default:   return pcoa_pkg::RAW_W'($urandom_range(0, (1 << pcoa_pkg::RAW_W) - 1));
    endcase
  endfunction

  function automatic pcoa_pkg::in_req_t random_reading();
    pcoa_pkg::in_req_t r;
    r.channel_index = pcoa_pkg::CHAN_W'($urandom_range(0, NUM_CH - 1));
    case ($urandom_range(0, 9))
      0:       r.raw_reading = fill_reading(FILL_ZERO);
      1:       r.raw_reading = fill_reading(FILL_FULL);
      default: r.raw_reading = fill_reading(FILL_RANDOM);
    endcase
    return r;
  endfunction

  task automatic send_random(input int n);
    repeat (n) send_reading(random_reading());
  endtask

  // Drop valid, wait for all expected results, then let the pipeline empty.
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (avg_expected_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 3) @(posedge clk_i);
  endtask

  task automatic write_scale(input logic [pcoa_pkg::SCALE_W-1:0] value);
    drain_and_settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    scale_reg = value;
    cfg_we_i  <= 1'b0;
  endtask

  // Full-scale block on channel 3 interleaved with zeros on channel 0, default scale.
  task automatic test_block_extremes();
    pcoa_pkg::in_req_t r;
    gaps_on  = 1'b0;
    rdy_mode = RDY_ALWAYS;
    for (int i = 0; i < BLOCK; i++) begin
      r.channel_index = pcoa_pkg::CHAN_W'(3);
      r.raw_reading   = fill_reading(FILL_FULL);
      send_reading(r);
      if (i < BLOCK / 2) begin
        r.channel_index = pcoa_pkg::CHAN_W'(0);
        r.raw_reading   = fill_reading(FILL_ZERO);
        send_reading(r);
      end
    end
  endtask

  // Bring every channel to one short of a block, then complete all back to back.
  task automatic cluster_completions(input fill_mode_e mode);
    int                need [NUM_CH];
    pcoa_pkg::in_req_t r;
    drain_and_settle();
    foreach (need[c]) need[c] = BLOCK - 1 - chan_count[c];
    for (int c = 0; c < NUM_CH; c++) begin
      repeat (need[c]) begin
        r.channel_index = pcoa_pkg::CHAN_W'(c);
        r.raw_reading   = fill_reading(mode);
        send_reading(r);
      end
    end
    for (int c = 0; c < NUM_CH; c++) begin
      r.channel_index = pcoa_pkg::CHAN_W'(c);
      r.raw_reading   = fill_reading(mode);
      send_reading(r);
    end
  endtask

  task automatic test_stall_pressure();
    gaps_on  = 1'b0;
    rdy_mode = RDY_BURSTY;
    cluster_completions(FILL_ZERO);
    cluster_completions(FILL_FULL);
    repeat (6) cluster_completions(FILL_RANDOM);
    send_random(80);
  endtask

  task automatic test_scale_settings();
    logic [pcoa_pkg::SCALE_W-1:0] scales [6];
    scales[0] = '0;
    scales[1] = '1;
    scales[2] = pcoa_pkg::SCALE_W'(100000);
    scales[3] = pcoa_pkg::SCALE_W'(1);
    scales[4] = pcoa_pkg::SCALE_W'(4095);
    scales[5] = pcoa_pkg::SCALE_W'($urandom_range(0, 100000));
    foreach (scales[i]) begin
      write_scale(scales[i]);
      gaps_on  = (i % 2 == 1);
      rdy_mode = ready_mode_e'(i % 3);
      send_random(60);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_block_extremes();
    test_stall_pressure();
    test_scale_settings();
    drain_and_settle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && avg_expected_q.size() == 0) begin
      $display("tb_per_channel_oversample_average: PASS");
    end else begin
      $display("tb_per_channel_oversample_average: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/pcoa_pkg.sv
sv/per_channel_oversample_average.sv
sim/tb_per_channel_oversample_average.sv
